[design/gar_pkg.sv]
package gar_pkg;

   localparam int REG_COUNT_DEFAULT = 64;
   localparam int CMD_W = 4;
   localparam int IDX_W = 6;
   localparam int DATA_W = 32;

   localparam logic [DATA_W-1:0] THREAD_COUNT_RESET = 32'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INC       = 4'd0,
      CMD_DEC       = 4'd1,
      CMD_ADD       = 4'd2,
      CMD_INC_RESET = 4'd3,
      CMD_BARRIER   = 4'd4,
      CMD_READ      = 4'd5,
      CMD_SEM_ACQ   = 4'd6,
      CMD_SEM_REL   = 4'd7,
      CMD_STORE     = 4'd8
   } cmd_type;

endpackage

[design/gar_intf.sv]
interface gar_req_if;
   logic                         valid;
   logic                         ready;
   logic [gar_pkg::CMD_W-1:0]    cmd;
   logic [gar_pkg::IDX_W-1:0]    reg_index;
   logic [gar_pkg::DATA_W-1:0]   operand_value;
   logic                         thread_write_ok;

   modport source (output valid, cmd, reg_index, operand_value, thread_write_ok,
                   input ready);
   modport sink (input valid, cmd, reg_index, operand_value, thread_write_ok,
                 output ready);
endinterface

interface gar_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic [gar_pkg::DATA_W-1:0]   result_value;
   logic                         writes_thread;

   modport source (output valid, accepted, result_value, writes_thread,
                   input ready);
   modport sink (input valid, accepted, result_value, writes_thread,
                 output ready);
endinterface

[design/global_atomic_register_file.sv]
// Global atomic register file.
// Items arrive on req_if (valid/ready): a command, a register index, an
// operand and a flag telling whether the thread write port is free. Each
// item yields exactly one result item on rsp_if: accepted, the value
// returned to the thread, and whether that value is written back.
// csr_wr_en/csr_wr_data load the thread count used by increment-reset;
// write it only while no item is in flight.
// Latency: an item accepted at edge N is read from memory at that edge; the
// modify/write-back loads the output register at edge N+1, so rsp_if.valid
// rises after edge N+1 and the result can be taken at edge N+2 at earliest.
// Throughput: one item per cycle; the single read-modify-write path through
// the register memory sets that figure, with a write-to-read forward
// covering back-to-back hits on one entry.
// Reset: the memory is swept to zero, one entry per cycle, for REG_COUNT
// cycles after reset falls; req_if.ready stays low during the sweep.
// The thread count returns to 1.
// Stall: when rsp_if.ready is low the result holds in the output register,
// the next item waits behind it in the read stage, and req_if.ready drops.
module global_atomic_register_file #(
   parameter int REG_COUNT = gar_pkg::REG_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   gar_req_if.sink                     req_if,
   gar_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [gar_pkg::DATA_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(REG_COUNT);
   localparam int DW = gar_pkg::DATA_W;

   logic [DW-1:0] mem [REG_COUNT];

   logic [DW-1:0] thread_count_ff;

   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic                   s1_valid_ff;
   gar_pkg::cmd_type       s1_cmd_ff;
   logic [AW-1:0]          s1_addr_ff;
   logic                   s1_in_range_ff;
   logic [DW-1:0]          s1_opv_ff;
   logic                   s1_ok_ff;
   logic [DW-1:0]          rdata_ff;
   logic                   fwd_hit_ff;
   logic [DW-1:0]          fwd_data_ff;

   logic          rsp_valid_ff;
   logic          rsp_acc_ff;
   logic [DW-1:0] rsp_res_ff;
   logic          rsp_wt_ff;

   logic          req_fire, s1_fire;
   logic [AW-1:0] rd_addr;
   logic          rd_in_range;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   logic          op_acc, op_wt, op_wr;
   logic [DW-1:0] op_res, op_new, old_val;

   // ---------------- handshakes ----------------
   assign s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !clr_ff && (!s1_valid_ff || s1_fire);
   assign req_fire      = req_if.valid && req_if.ready;

   assign rd_addr     = AW'({{AW{1'b0}}, req_if.reg_index});
   assign rd_in_range = ({{(32-gar_pkg::IDX_W){1'b0}}, req_if.reg_index} < 32'(REG_COUNT));

   // ---------------- clearing sweep ----------------
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(REG_COUNT - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------- thread count ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thread_count_ff <= gar_pkg::THREAD_COUNT_RESET;
      end else if (csr_wr_en) begin
         thread_count_ff <= csr_wr_data;
      end
   end

   // ---------------- modify ----------------
   assign old_val = !s1_in_range_ff ? '0 : (fwd_hit_ff ? fwd_data_ff : rdata_ff);

   always_comb begin
      op_acc = 1'b1;
      op_wt  = 1'b0;
      op_wr  = 1'b0;
      op_res = '0;
      op_new = old_val;
      unique case (s1_cmd_ff) inside
         gar_pkg::CMD_INC, gar_pkg::CMD_DEC, gar_pkg::CMD_ADD,
         gar_pkg::CMD_INC_RESET, gar_pkg::CMD_READ: begin
            if (!s1_ok_ff) begin
               op_acc = 1'b0;
            end else begin
               op_wt  = 1'b1;
               op_res = old_val;
               op_wr  = (s1_cmd_ff != gar_pkg::CMD_READ);
               case (s1_cmd_ff)
                  gar_pkg::CMD_INC: op_new = old_val + 1'b1;
                  gar_pkg::CMD_DEC: op_new = old_val - 1'b1;
                  gar_pkg::CMD_ADD: begin
                     op_new = old_val + s1_opv_ff;
                     op_res = old_val + s1_opv_ff;
                  end
                  gar_pkg::CMD_INC_RESET:
                     op_new = (old_val == thread_count_ff - 1'b1) ? '0 : old_val + 1'b1;
                  default: op_new = old_val;
               endcase
            end
         end
         gar_pkg::CMD_BARRIER: begin
            op_acc = (old_val == '0);
         end
         gar_pkg::CMD_SEM_ACQ: begin
            op_acc = (old_val == '0);
            op_wr  = (old_val == '0);
            op_new = DW'(1);
         end
         gar_pkg::CMD_SEM_REL: begin
            op_wr  = 1'b1;
            op_new = '0;
         end
         gar_pkg::CMD_STORE: begin
            op_wr  = 1'b1;
            op_new = s1_opv_ff;
         end
         default: begin
            op_acc = 1'b1;
         end
      endcase
   end

   // drop writes beyond the store; the sweep owns the port after reset
   assign wr_en   = clr_ff || (s1_fire && op_wr && s1_in_range_ff);
   assign wr_addr = clr_ff ? clr_cnt_ff : s1_addr_ff;
   assign wr_data = clr_ff ? '0 : op_new;

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_fire) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // ---------------- read stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff      <= gar_pkg::cmd_type'(req_if.cmd);
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= rd_in_range;
         s1_opv_ff      <= req_if.operand_value;
         s1_ok_ff       <= req_if.thread_write_ok;
         // the memory returns the old word when written in the same cycle
         fwd_hit_ff     <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff    <= wr_data;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_acc_ff <= op_acc;
         rsp_res_ff <= op_wt ? op_res : '0;
         rsp_wt_ff  <= op_wt;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.accepted      = rsp_acc_ff;
   assign rsp_if.result_value  = rsp_res_ff;
   assign rsp_if.writes_thread = rsp_wt_ff;

   // ---------------- assertions ----------------
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_if.ready)
      else $error("item taken during memory sweep");

   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> clr_ff && (clr_cnt_ff == '0))
      else $error("memory sweep did not restart after reset");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("finished item produced no result");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_if.ready |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("read stage lost its item during stall");

   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !op_acc |-> !wr_en)
      else $error("rejected item changed the store");

endmodule

[dv/tb_global_atomic_register_file.sv]
module tb_global_atomic_register_file;

   localparam int REG_COUNT = gar_pkg::REG_COUNT_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 188;
   localparam int NUM_SETTINGS = 6;
   localparam logic [gar_pkg::CMD_W-1:0] CMD_NONE_LO = gar_pkg::CMD_W'(gar_pkg::CMD_STORE + 1);
   localparam logic [gar_pkg::CMD_W-1:0] CMD_NONE_HI = '1;

   typedef struct packed {
      logic [gar_pkg::CMD_W-1:0]  cmd;
      logic [gar_pkg::IDX_W-1:0]  reg_index;
      logic [gar_pkg::DATA_W-1:0] operand_value;
      logic                       thread_write_ok;
   } instr_type;

   typedef struct packed {
      logic                       accepted;
      logic [gar_pkg::DATA_W-1:0] result_value;
      logic                       writes_thread;
   } outcome_type;

   typedef struct packed {
      instr_type   ins;
      logic        typed;
      outcome_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [gar_pkg::DATA_W-1:0] csr_wr_data;

   gar_req_if req_if ();
   gar_rsp_if rsp_if ();

   global_atomic_register_file #(.REG_COUNT(REG_COUNT)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // model of the register file and the thread count
   logic [gar_pkg::DATA_W-1:0] regfile_model [REG_COUNT];
   logic [gar_pkg::DATA_W-1:0] thread_count_model;
   outcome_type                outcome_q [$];
   outcome_type                oldest;

   int  err_count = 0;
   int  quiet_cycles = 0;
   int  issued_count = 0;
   int  rejected_count = 0;
   int  checked_count = 0;
   bit  gaps_on = 1'b1;

   logic [gar_pkg::DATA_W-1:0] tc_settings [NUM_SETTINGS] =
      '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd7, 32'd1};

   directed_row_type directed_rows [25] = '{
      '{'{gar_pkg::CMD_READ,      6'd0,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_READ,      6'd63, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_INC,       6'd0,  32'd0,         1'b0}, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_INC,       6'd0,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_INC,       6'd0,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd1, 1'b1}},
      '{'{gar_pkg::CMD_DEC,       6'd1,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_READ,      6'd1,  32'd0,         1'b1}, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{'{gar_pkg::CMD_INC,       6'd1,  32'd0,         1'b1}, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{'{gar_pkg::CMD_ADD,       6'd2,  32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{'{gar_pkg::CMD_ADD,       6'd2,  32'd1,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_ADD,       6'd2,  32'd5,         1'b0}, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_INC_RESET, 6'd3,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_READ,      6'd3,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b1}},
      '{'{gar_pkg::CMD_STORE,     6'd4,  32'hFFFF_FFFF, 1'b0}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_READ,      6'd4,  32'd0,         1'b1}, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b1}},
      '{'{gar_pkg::CMD_BARRIER,   6'd4,  32'd0,         1'b1}, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_BARRIER,   6'd5,  32'd0,         1'b0}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_SEM_ACQ,   6'd5,  32'd0,         1'b0}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_SEM_ACQ,   6'd5,  32'd0,         1'b1}, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_SEM_REL,   6'd5,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_SEM_REL,   6'd5,  32'd0,         1'b0}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_SEM_ACQ,   6'd5,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{CMD_NONE_LO,            6'd5,  32'h1234_5678, 1'b1}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{CMD_NONE_HI,            6'd63, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{'{gar_pkg::CMD_READ,      6'd5,  32'd0,         1'b1}, 1'b1, '{1'b1, 32'd1, 1'b1}}
   };

   task automatic report_mismatch(string what, logic [gar_pkg::DATA_W-1:0] got,
                                  logic [gar_pkg::DATA_W-1:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      err_count++;
   endtask

   function automatic void model_store(logic [gar_pkg::IDX_W-1:0] idx,
                                       logic [gar_pkg::DATA_W-1:0] value);
      if (idx < REG_COUNT)
         regfile_model[idx] = value;
   endfunction

   function automatic outcome_type execute_atomic(instr_type ins);
      outcome_type                o;
      logic [gar_pkg::DATA_W-1:0] old;
      o = '0;
      o.accepted = 1'b1;
      old = (ins.reg_index < REG_COUNT) ? regfile_model[ins.reg_index] : '0;
      case (ins.cmd) inside
         gar_pkg::CMD_INC, gar_pkg::CMD_DEC, gar_pkg::CMD_ADD, gar_pkg::CMD_INC_RESET,
         gar_pkg::CMD_READ: begin
            if (!ins.thread_write_ok) begin
               o.accepted = 1'b0;
            end else begin
               o.writes_thread = 1'b1;
               o.result_value = old;
               case (ins.cmd)
                  gar_pkg::CMD_INC: model_store(ins.reg_index, old + 32'd1);
                  gar_pkg::CMD_DEC: model_store(ins.reg_index, old - 32'd1);
                  gar_pkg::CMD_ADD: begin
                     o.result_value = old + ins.operand_value;
                     model_store(ins.reg_index, o.result_value);
                  end
                  gar_pkg::CMD_INC_RESET:
                     model_store(ins.reg_index,
                                 (old == thread_count_model - 32'd1) ? '0 : old + 32'd1);
                  default: ;
               endcase
            end
         end
         gar_pkg::CMD_BARRIER: o.accepted = (old == '0);
         gar_pkg::CMD_SEM_ACQ: begin
            if (old != '0)
               o.accepted = 1'b0;
            else
               model_store(ins.reg_index, 32'd1);
         end
         gar_pkg::CMD_SEM_REL: model_store(ins.reg_index, '0);
         gar_pkg::CMD_STORE: model_store(ins.reg_index, ins.operand_value);
         default: ;
      endcase
      return o;
   endfunction

   // bias toward a few hot registers so counters, semaphores and wraps interact
   function automatic instr_type random_instr();
      instr_type ins;
      int        pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)      ins.cmd = gar_pkg::CMD_INC;
      else if (pick < 22) ins.cmd = gar_pkg::CMD_DEC;
      else if (pick < 32) ins.cmd = gar_pkg::CMD_ADD;
      else if (pick < 50) ins.cmd = gar_pkg::CMD_INC_RESET;
      else if (pick < 58) ins.cmd = gar_pkg::CMD_BARRIER;
      else if (pick < 66) ins.cmd = gar_pkg::CMD_READ;
      else if (pick < 76) ins.cmd = gar_pkg::CMD_SEM_ACQ;
      else if (pick < 84) ins.cmd = gar_pkg::CMD_SEM_REL;
      else if (pick < 95) ins.cmd = gar_pkg::CMD_STORE;
      else                ins.cmd = gar_pkg::CMD_W'($urandom_range(CMD_NONE_LO, CMD_NONE_HI));
      ins.reg_index = ($urandom_range(0, 3) != 0) ? gar_pkg::IDX_W'($urandom_range(0, 3))
                                                  : gar_pkg::IDX_W'($urandom_range(0, 63));
      case ($urandom_range(0, 5))
         0: ins.operand_value = thread_count_model - 32'd1;
         1: ins.operand_value = thread_count_model - 32'd2;
         2: ins.operand_value = '0;
         3: ins.operand_value = '1;
         default: ins.operand_value = $urandom;
      endcase
      ins.thread_write_ok = ($urandom_range(0, 6) != 0);
      return ins;
   endfunction

   task automatic send_item(instr_type ins, logic typed, outcome_type want);
      outcome_type pred;
      req_if.valid <= 1'b1;
      req_if.cmd <= ins.cmd;
      req_if.reg_index <= ins.reg_index;
      req_if.operand_value <= ins.operand_value;
      req_if.thread_write_ok <= ins.thread_write_ok;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      pred = execute_atomic(ins);
      if (typed)
         pred = want;
      outcome_q.push_back(pred);
      issued_count++;
      if (!pred.accepted)
         rejected_count++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // hold off until every result is back and the pipeline is idle
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         checked_count++;
         if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_if.result_value, '0);
         end else begin
            oldest = outcome_q.pop_front();
            if (rsp_if.accepted !== oldest.accepted)
               report_mismatch("accepted", 32'(rsp_if.accepted), 32'(oldest.accepted));
            if (rsp_if.result_value !== oldest.result_value)
               report_mismatch("result_value", rsp_if.result_value, oldest.result_value);
            if (rsp_if.writes_thread !== oldest.writes_thread)
               report_mismatch("writes_thread", 32'(rsp_if.writes_thread),
                               32'(oldest.writes_thread));
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (gaps_on && $urandom_range(0, 1) == 1) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd <= '0;
      req_if.reg_index <= '0;
      req_if.operand_value <= '0;
      req_if.thread_write_ok <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      foreach (regfile_model[i])
         regfile_model[i] = '0;
      thread_count_model = gar_pkg::THREAD_COUNT_RESET;
      tc_settings[4] = $urandom_range(4, 40);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         drain_pipeline();
         csr_wr_en <= 1'b1;
         csr_wr_data <= tc_settings[p];
         @(posedge clock);
         thread_count_model = tc_settings[p];
         csr_wr_en <= 1'b0;
         // finish with a stretch at full rate on both sides
         gaps_on = (p != NUM_SETTINGS - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_instr(), 1'b0, '0);
      end
      drain_pipeline();
      repeat (8) @(posedge clock);

      $display("Summary: %0d instructions issued across %0d thread-count settings, %0d rejected",
               issued_count, NUM_SETTINGS + 1, rejected_count);
      $display("Summary: %0d results compared, %0d mismatches", checked_count, err_count);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
